[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the pressure compensation core.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// Shared types and constants of the pressure compensation core.
// No dependencies; imported by every module of the core.
`default_nettype none

package bpc_pkg;

	// pipeline depth: one valid bit per stage
	localparam int NSTG = 9;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS      = 3'd0,
		REG_OFFSET    = 3'd1,
		REG_SENS_TC   = 3'd2,
		REG_OFFSET_TC = 3'd3,
		REG_REF_TEMP  = 3'd4,
		REG_TEMP_SLOPE = 3'd5,
		REG_VARIANT   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] sens_coeff;
		logic [15:0] offset_coeff;
		logic [15:0] sens_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] ref_temp;
		logic [15:0] temp_slope;
		logic        variant;
	} coeff_t;

	typedef struct packed {
		logic [NSTG-1:0] en;   // stage loads this cycle
		logic [NSTG-1:0] vld;  // stage holds a request
	} pipe_ctl_t;

	// datapath widths, from the ranges of 24-bit conversions and 16-bit coefficients
	localparam int DT_W   = 25;
	localparam int TEMP_W = 19;
	localparam int TOUT_W = 20;
	localparam int SQ_W   = 38;
	localparam int OFF_W  = 42;
	localparam int SENS_W = 41;
	localparam int PRES_W = 29;

	localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_LOW = -19'sd1500;

	// second-order factors, standard set
	localparam logic signed [7:0] K0_OFF_D  = 8'sd61;
	localparam logic signed [7:0] K0_SENS_D = 8'sd2;
	localparam logic signed [7:0] K0_OFF_E  = 8'sd15;
	localparam logic signed [7:0] K0_SENS_E = 8'sd8;
	// second-order factors, alternate set
	localparam logic signed [7:0] K1_OFF_D  = 8'sd5;
	localparam logic signed [7:0] K1_SENS_D = 8'sd5;
	localparam logic signed [7:0] K1_OFF_E  = 8'sd7;
	localparam logic signed [7:0] K1_SENS_E = 8'sd11;

endpackage

`default_nettype wire

[rtl/barometer_pressure_compensation_core.sv]
// Pressure compensation core: nine register stages between an accepted request
// and its result; one request per cycle sustained while the output is ready.
// Each stage has its own valid bit and loads when empty or when its successor
// moves, so bubbles close up under output backpressure; widest multiplier 25x25.
// Reset (arst_n low, asynchronous) clears all valid bits and the coefficients.
`default_nettype none
`include "assert_macros.svh"

module barometer_pressure_compensation_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
	// raw conversions
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [47:0]                   s_axis_tdata,  // raw_temp[23:0], raw_press[47:24]
	// compensated results
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [63:0]                        m_axis_tdata   // pressure[31:0], temperature[63:32]
);
	import bpc_pkg::*;

	coeff_t    cf;
	pipe_ctl_t ctl;

	bpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.coeff    (cf)
	);

	bpc_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	// Coefficients must be changed only while the pipeline is empty (the core does
	// not enforce this), so every stage reads them directly instead of carrying a copy along.

	// ---------------------------------------------------------------
	// Stage 1: dT = D2 - C5*256
	// ---------------------------------------------------------------
	logic signed [DT_W-1:0] dt_s1;
	logic [23:0]            d1_s1;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			dt_s1 <= $signed({1'b0, s_axis_tdata[23:0]}) - $signed({1'b0, cf.ref_temp, 8'h00});
			d1_s1 <= s_axis_tdata[47:24];
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: the four products of dT
	// ---------------------------------------------------------------
	logic signed [41:0] p6_s2, p4_s2, p3_s2;
	logic signed [49:0] pdt_s2;
	logic [23:0]        d1_s2;

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			p6_s2  <= 42'(dt_s1) * 42'($signed({1'b0, cf.temp_slope}));
			p4_s2  <= 42'(dt_s1) * 42'($signed({1'b0, cf.offset_temp_coeff}));
			p3_s2  <= 42'(dt_s1) * 42'($signed({1'b0, cf.sens_temp_coeff}));
			pdt_s2 <= 50'(dt_s1) * 50'(dt_s1);
			d1_s2  <= d1_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: TEMP, first-order OFF and SENS, T2 = dT^2 >> 31
	// ---------------------------------------------------------------
	logic signed [TEMP_W-1:0] temp_s3;
	logic signed [OFF_W-1:0]  offb_s3;
	logic signed [SENS_W-1:0] sensb_s3;
	logic [17:0]              t2_s3;
	logic [23:0]              d1_s3;

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			// upper bits of the product are the floor shift by 23
			temp_s3 <= $signed(p6_s2[41:23]) + TEMP_REF;
			if (cf.variant) begin
				offb_s3  <= OFF_W'($signed({1'b0, cf.offset_coeff, 16'h0000})) + (p4_s2 >>> 7);
				sensb_s3 <= SENS_W'($signed({1'b0, cf.sens_coeff, 15'h0000}))
					+ SENS_W'(p3_s2 >>> 8);
			end else begin
				offb_s3  <= OFF_W'($signed({1'b0, cf.offset_coeff, 17'h00000})) + (p4_s2 >>> 6);
				sensb_s3 <= SENS_W'($signed({1'b0, cf.sens_coeff, 16'h0000}))
					+ SENS_W'(p3_s2 >>> 7);
			end
			t2_s3 <= pdt_s2[48:31];
			d1_s3 <= d1_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: squares of the distances below 20.00 and -15.00 degC,
	// corrected output temperature
	// ---------------------------------------------------------------
	logic signed [TEMP_W-1:0] dist_d, diste_d;
	logic signed [SQ_W-1:0]   dd_s4, ee_s4;
	logic                     lt2_s4, lt15_s4;
	logic signed [TOUT_W-1:0] tout_s4;
	logic signed [OFF_W-1:0]  offb_s4;
	logic signed [SENS_W-1:0] sensb_s4;
	logic [23:0]              d1_s4;

	assign dist_d  = temp_s3 - TEMP_REF;
	assign diste_d = temp_s3 - TEMP_LOW;

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			dd_s4   <= SQ_W'(dist_d) * SQ_W'(dist_d);
			ee_s4   <= SQ_W'(diste_d) * SQ_W'(diste_d);
			lt2_s4  <= temp_s3 < TEMP_REF;
			lt15_s4 <= temp_s3 < TEMP_LOW;
			if (temp_s3 < TEMP_REF) begin
				tout_s4 <= TOUT_W'(temp_s3) - TOUT_W'($signed({1'b0, t2_s3}));
			end else begin
				tout_s4 <= TOUT_W'(temp_s3);
			end
			offb_s4  <= offb_s3;
			sensb_s4 <= sensb_s3;
			d1_s4    <= d1_s3;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: second-order terms OFF2 and SENS2
	// ---------------------------------------------------------------
	logic signed [OFF_W-1:0]  off2_d, off2e_d;
	logic signed [SENS_W-1:0] sens2_d, sens2e_d;
	logic signed [OFF_W-1:0]  off2_s5, offb_s5;
	logic signed [SENS_W-1:0] sens2_s5, sensb_s5;
	logic signed [TOUT_W-1:0] tout_s5;
	logic [23:0]              d1_s5;

	always_comb begin
		off2_d   = '0;
		sens2_d  = '0;
		off2e_d  = '0;
		sens2e_d = '0;
		if (lt2_s4) begin
			if (cf.variant) begin
				off2_d  = OFF_W'(dd_s4 >>> 1) * OFF_W'(K1_OFF_D);
				sens2_d = SENS_W'(dd_s4 >>> 2) * SENS_W'(K1_SENS_D);
				if (lt15_s4) begin
					off2e_d  = OFF_W'(ee_s4) * OFF_W'(K1_OFF_E);
					sens2e_d = (SENS_W'(ee_s4) * SENS_W'(K1_SENS_E)) >>> 1;
				end
			end else begin
				off2_d  = OFF_W'(dd_s4 >>> 4) * OFF_W'(K0_OFF_D);
				sens2_d = SENS_W'(dd_s4) * SENS_W'(K0_SENS_D);
				if (lt15_s4) begin
					off2e_d  = OFF_W'(ee_s4) * OFF_W'(K0_OFF_E);
					sens2e_d = SENS_W'(ee_s4) * SENS_W'(K0_SENS_E);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			off2_s5  <= off2_d + off2e_d;
			sens2_s5 <= sens2_d + sens2e_d;
			offb_s5  <= offb_s4;
			sensb_s5 <= sensb_s4;
			tout_s5  <= tout_s4;
			d1_s5    <= d1_s4;
		end
	end

	// ---------------------------------------------------------------
	// Stage 6: final OFF and SENS
	// ---------------------------------------------------------------
	logic signed [OFF_W-1:0]  off_s6;
	logic signed [SENS_W-1:0] sens_s6;
	logic signed [TOUT_W-1:0] tout_s6;
	logic [23:0]              d1_s6;

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			off_s6  <= offb_s5 - off2_s5;
			sens_s6 <= sensb_s5 - sens2_s5;
			tout_s6 <= tout_s5;
			d1_s6   <= d1_s5;
		end
	end

	// ---------------------------------------------------------------
	// Stage 7: D1*SENS as two partial products over the halves of SENS
	// ---------------------------------------------------------------
	logic [43:0]              pl_s7;
	logic signed [45:0]       ph_s7;
	logic signed [OFF_W-1:0]  off_s7;
	logic signed [TOUT_W-1:0] tout_s7;

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			pl_s7   <= 44'(d1_s6) * 44'(sens_s6[19:0]);
			ph_s7   <= 46'($signed({1'b0, d1_s6})) * 46'($signed(sens_s6[SENS_W-1:20]));
			off_s7  <= off_s6;
			tout_s7 <= tout_s6;
		end
	end

	// ---------------------------------------------------------------
	// Stage 8: combine the partial products
	// ---------------------------------------------------------------
	logic signed [63:0]       prod_s8;
	logic signed [OFF_W-1:0]  off_s8;
	logic signed [TOUT_W-1:0] tout_s8;

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			prod_s8 <= (64'(ph_s7) <<< 20) + $signed({20'h00000, pl_s7});
			off_s8  <= off_s7;
			tout_s8 <= tout_s7;
		end
	end

	// ---------------------------------------------------------------
	// Stage 9: P = ((D1*SENS >> 21) - OFF) >> 15
	// The result stays within 29 signed bits for any 24-bit conversions
	// and 16-bit coefficients, so the 32-bit clamp reduces to sign extension.
	// ---------------------------------------------------------------
	logic signed [43:0]       pdiff_d;
	logic signed [PRES_W-1:0] pres_s9;
	logic signed [TOUT_W-1:0] tout_s9;

	assign pdiff_d = 44'($signed(prod_s8[63:21])) - 44'(off_s8);

	always_ff @(posedge clk) begin
		if (ctl.en[8]) begin
			pres_s9 <= pdiff_d[43:15];
			tout_s9 <= tout_s8;
		end
	end

	assign m_axis_tvalid = ctl.vld[NSTG-1];
	assign m_axis_tdata  = {32'(tout_s9), 32'(pres_s9)};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_axis_tvalid && s_axis_tready, ctl.vld[0], "accepted request missing from stage 1")
	`ASSERT_ALWAYS(a_stall_only_full, clk, arst_n, s_axis_tready || (&ctl.vld), "input stalled while a stage is empty")
	`ASSERT_NEXT(a_tout_not_above, clk, arst_n, ctl.en[3] && ctl.vld[2], 32'(tout_s4) <= 32'($past(temp_s3)), "second-order correction raised the temperature")

endmodule

`default_nettype wire

[rtl/bpc_cfg_regs.sv]
// Calibration coefficient and variant registers of the compensation core.
// Depends on bpc_pkg.
`default_nettype none

module bpc_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
	output bpc_pkg::coeff_t                    coeff
);
	import bpc_pkg::*;

	coeff_t coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_SENS:       coeff_q.sens_coeff        <= cfg_data;
				REG_OFFSET:     coeff_q.offset_coeff      <= cfg_data;
				REG_SENS_TC:    coeff_q.sens_temp_coeff   <= cfg_data;
				REG_OFFSET_TC:  coeff_q.offset_temp_coeff <= cfg_data;
				REG_REF_TEMP:   coeff_q.ref_temp          <= cfg_data;
				REG_TEMP_SLOPE: coeff_q.temp_slope        <= cfg_data;
				REG_VARIANT:    coeff_q.variant           <= cfg_data[0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	assign coeff = coeff_q;

endmodule

`default_nettype wire

[rtl/bpc_pipe_ctl.sv]
// Valid and load-enable control for the stages of the compensation pipeline.
// Depends on bpc_pkg.
`default_nettype none

module bpc_pipe_ctl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         out_ready,
	output bpc_pkg::pipe_ctl_t ctl
);
	import bpc_pkg::*;

	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   rdy;
	logic [NSTG-1:0] vld_in;

	// a stage may load when empty or when the stage after it moves
	always_comb begin
		rdy[NSTG] = out_ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			rdy[k] = ~vld_q[k] | rdy[k+1];
		end
	end

	assign vld_in = {vld_q[NSTG-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign in_ready = rdy[0];
	assign ctl.en   = rdy[NSTG-1:0];
	assign ctl.vld  = vld_q;

endmodule

`default_nettype wire

[test/barometer_pressure_compensation_core_tb.sv]
// Self-checking testbench of the barometer pressure compensation core.
// Depends on bpc_pkg and the core; a built-in predictor checks every result in order.
`default_nettype none

module barometer_pressure_compensation_core_tb;
	import bpc_pkg::*;

	// index past the last register: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE_LIMIT = 2000;
	localparam int LOG_LIMIT    = 10;

	// fields from the lowest bit up: raw_temp, raw_press
	typedef struct packed {
		logic [23:0] raw_press;
		logic [23:0] raw_temp;
	} conversion_t;

	// fields from the lowest bit up: pressure, temperature
	typedef struct packed {
		logic signed [31:0] temperature;
		logic signed [31:0] pressure;
	} reading_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx       = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [47:0]           s_axis_tdata  = '0;  // raw_temp[23:0], raw_press[47:24]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [63:0]           m_axis_tdata;        // pressure[31:0], temperature[63:32]

	// calibration as the core should hold it
	coeff_t cal = '0;

	conversion_t conversions_q[$];  // requests waiting to be offered
	reading_t    readings_q[$];     // predicted results, oldest first

	int sent_count  = 0;  // requests put on the bus
	int taken_count = 0;  // requests accepted by the core
	int errors      = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// one-shot triggers from the sequence, each consumed by its own process
	int  hold_req   = 0;
	int  hold_seen  = 0;
	int  hold_left  = 0;
	int  pause_req  = 0;
	int  pause_seen = 0;
	bit  tx_paused  = 1'b0;

	reading_t got_reading;
	reading_t want_reading;

	barometer_pressure_compensation_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Compensated reading for one raw pair under the current calibration.
	// Everything is carried in signed 64 bits; >>> floors like the sensor math.
	function automatic reading_t compensate(conversion_t conv);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, temp, off, sens, tout, p, d, dd, e, ee, off2, sens2;
		reading_t r;
		d2 = longint'({40'd0, conv.raw_temp});
		d1 = longint'({40'd0, conv.raw_press});
		c1 = longint'({48'd0, cal.sens_coeff});
		c2 = longint'({48'd0, cal.offset_coeff});
		c3 = longint'({48'd0, cal.sens_temp_coeff});
		c4 = longint'({48'd0, cal.offset_temp_coeff});
		c5 = longint'({48'd0, cal.ref_temp});
		c6 = longint'({48'd0, cal.temp_slope});

		dt   = d2 - c5 * 256;
		temp = TEMP_REF + ((dt * c6) >>> 23);

		if (cal.variant) begin
			off  = c2 * 65536 + ((dt * c4) >>> 7);
			sens = c1 * 32768 + ((dt * c3) >>> 8);
		end else begin
			off  = c2 * 131072 + ((dt * c4) >>> 6);
			sens = c1 * 65536 + ((dt * c3) >>> 7);
		end

		// second-order terms come from the uncorrected temperature
		tout = temp;
		if (temp < TEMP_REF) begin
			d    = temp - TEMP_REF;
			dd   = d * d;
			tout = temp - ((dt * dt) >>> 31);
			if (cal.variant) begin
				off2  = K1_OFF_D * (dd >>> 1);
				sens2 = K1_SENS_D * (dd >>> 2);
			end else begin
				off2  = K0_OFF_D * (dd >>> 4);
				sens2 = K0_SENS_D * dd;
			end
			if (temp < TEMP_LOW) begin
				e  = temp - TEMP_LOW;
				ee = e * e;
				if (cal.variant) begin
					off2  += K1_OFF_E * ee;
					sens2 += (K1_SENS_E * ee) >>> 1;
				end else begin
					off2  += K0_OFF_E * ee;
					sens2 += K0_SENS_E * ee;
				end
			end
			off  -= off2;
			sens -= sens2;
		end

		p = (((d1 * sens) >>> 21) - off) >>> 15;
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;

		r.pressure    = p[31:0];
		r.temperature = tout[31:0];
		return r;
	endfunction

	// Write one register and track it; values are cut to the register width.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		case (idx)
			REG_SENS:       cal.sens_coeff        = value;
			REG_OFFSET:     cal.offset_coeff      = value;
			REG_SENS_TC:    cal.sens_temp_coeff   = value;
			REG_OFFSET_TC:  cal.offset_temp_coeff = value;
			REG_REF_TEMP:   cal.ref_temp          = value;
			REG_TEMP_SLOPE: cal.temp_slope        = value;
			REG_VARIANT:    cal.variant           = value[0];
			default:        ;
		endcase
	endtask

	task automatic load_cal(logic [15:0] c1, logic [15:0] c2, logic [15:0] c3,
			logic [15:0] c4, logic [15:0] c5, logic [15:0] c6, logic [15:0] sel);
		write_reg(REG_SENS, c1);
		write_reg(REG_OFFSET, c2);
		write_reg(REG_SENS_TC, c3);
		write_reg(REG_OFFSET_TC, c4);
		write_reg(REG_REF_TEMP, c5);
		write_reg(REG_TEMP_SLOPE, c6);
		write_reg(REG_VARIANT, sel);
	endtask

	// Load a fully random calibration, variant word included.
	task automatic load_random_cal();
		load_cal(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
			16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
			16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
			16'($urandom_range(16'hFFFF)));
	endtask

	// Queue one request; the temperature code is clipped into 24 bits.
	task automatic queue_conv(longint raw_temp, logic [23:0] raw_press);
		conversion_t c;
		if (raw_temp < 0)
			c.raw_temp = '0;
		else if (raw_temp > 64'sd16777215)
			c.raw_temp = '1;
		else
			c.raw_temp = raw_temp[23:0];
		c.raw_press = raw_press;
		conversions_q.push_back(c);
	endtask

	// Field extremes plus the points where the correction branches switch:
	// exactly 20.00 degC, one code below it, and the -15.00 degC edge.
	task automatic add_directed();
		longint center, cold_edge;
		center = longint'({48'd0, cal.ref_temp}) * 256;
		if (cal.temp_slope == 0)
			cold_edge = center;
		else
			cold_edge = center - (longint'(TEMP_REF - TEMP_LOW) * 64'sd8388608)
				/ longint'({48'd0, cal.temp_slope});
		queue_conv(0, 24'h000000);
		queue_conv(64'sd16777215, 24'hFFFFFF);
		queue_conv(0, 24'hFFFFFF);
		queue_conv(64'sd16777215, 24'h000000);
		queue_conv(center, 24'd8000000);
		queue_conv(center - 1, 24'd8000000);
		queue_conv(center + 1, 24'd9085466);
		queue_conv(center - 300000, 24'd9085466);
		queue_conv(cold_edge, 24'd9085466);
		queue_conv(cold_edge - 1, 24'd9085466);
		queue_conv(64'sd11184810, 24'h555555);
	endtask

	// Mostly temperatures around the reference point, where the branches
	// and the second-order terms all get exercised; the rest uniform.
	task automatic add_random(int count);
		longint center, t, span;
		center = longint'({48'd0, cal.ref_temp}) * 256;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0) begin
				t = longint'($urandom_range(24'hFFFFFF));
			end else begin
				span = longint'(1) << $urandom_range(22, 2);
				t = center + longint'($urandom_range(32'(2 * span))) - span;
			end
			queue_conv(t, 24'($urandom_range(24'hFFFFFF)));
		end
	endtask

	// Hold until every request is accepted and every result has come back.
	task automatic settle();
		int guard;
		guard = 0;
		while (conversions_q.size() != 0 || sent_count != taken_count)
			@(posedge clk);
		while (readings_q.size() != 0 && guard < SETTLE_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Request driver: present a new request only once the previous one was
	// taken, so tvalid never drops while a request is pending.
	always @(negedge clk) begin
		if (sent_count == taken_count) begin
			if (pause_seen != pause_req) begin
				pause_seen = pause_req;
				tx_paused  = 1'b1;
			end
			// release the pause once the core has emptied out
			if (tx_paused && readings_q.size() == 0)
				tx_paused = 1'b0;
			if (!tx_paused && conversions_q.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				s_axis_tdata  <= conversions_q.pop_front();
				s_axis_tvalid <= 1'b1;
				sent_count++;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result sink: random backpressure, plus a long hold-off on request
	// so the pipeline fills and pushes back on its input.
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: predict on every accepted request, compare every result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				readings_q.push_back(compensate(s_axis_tdata));
				taken_count++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_reading = m_axis_tdata;
				if (readings_q.size() == 0) begin
					errors++;
					if (errors <= LOG_LIMIT)
						$display("unexpected result: pressure %0d temperature %0d",
							got_reading.pressure, got_reading.temperature);
				end else begin
					want_reading = readings_q.pop_front();
					if (got_reading.pressure !== want_reading.pressure
							|| got_reading.temperature !== want_reading.temperature) begin
						errors++;
						if (errors <= LOG_LIMIT)
							$display("mismatch: pressure exp %0d got %0d, temperature exp %0d got %0d",
								want_reading.pressure, got_reading.pressure,
								want_reading.temperature, got_reading.temperature);
					end
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender idles more lightly than the receiver
		send_idle_pct = 37;
		recv_idle_pct = 48;

		// calibration straight out of reset: all zero
		add_random(60);
		settle();

		// typical factory calibration, standard shift set
		load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312, 16'd0);
		add_directed();
		add_random(175);
		settle();

		// same calibration, alternate shift set
		write_reg(REG_VARIANT, 16'd1);
		add_directed();
		add_random(175);
		settle();

		// now the receiver is the lighter side
		send_idle_pct = 48;
		recv_idle_pct = 37;

		// all coefficients at full scale; only bit 0 of the variant word counts,
		// and a write past the last register must leave everything alone
		load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		write_reg(REG_UNUSED, 16'h0000);
		add_random(175);
		settle();

		// full scale, standard set; halfway through, stop sending until drained
		write_reg(REG_VARIANT, 16'hFFFE);
		add_random(175);
		while (conversions_q.size() > 90)
			@(posedge clk);
		pause_req++;
		settle();

		load_random_cal();
		add_random(175);
		settle();

		// no idling on either side from here
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// random calibration; stall the output long enough to back up the input
		load_random_cal();
		add_random(175);
		while (conversions_q.size() > 165)
			@(posedge clk);
		hold_req++;
		settle();

		load_random_cal();
		add_random(175);
		settle();

		// catch any stray result that trails the last one
		repeat (NSTG + 4) @(posedge clk);
		if (errors == 0 && readings_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
